// ----- rtl/crc8_framed_packet_receiver_unit_assert.svh -----
// assertion macros for the crc-8 framed packet receiver
// no dependencies; included by the top level, which checks its own logic
`ifndef CRC8_FRAMED_PACKET_RECEIVER_UNIT_ASSERT_SVH
`define CRC8_FRAMED_PACKET_RECEIVER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication, sampled on clk, off while arst_n is low
`define CRC8FPR_ASSERT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("crc8fpr assertion failed");

// next-cycle implication
`define CRC8FPR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("crc8fpr assertion failed");

`else

`define CRC8FPR_ASSERT(lbl, ante, cons)
`define CRC8FPR_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ----- rtl/crc8fpr_pkg.sv -----
// shared types, constants and functions of the crc-8 framed packet receiver
// no dependencies
package crc8fpr_pkg;

	// configuration port
	localparam int AddrBits = 3;
	localparam int DataBits = 32;
	localparam logic RegSync  = 1'b0;
	localparam logic RegLimit = 1'b1;

	localparam logic [7:0]  SyncReset  = 8'hAA;
	localparam logic [30:0] LimitReset = 31'h461C4000;   // 10000.0

	// frame layout: position 1..10 feed the crc, 11 is the check byte
	localparam logic [3:0] PosHunt  = 4'd0;
	localparam logic [3:0] PosFirst = 4'd1;
	localparam logic [3:0] CrcLast  = 4'd10;
	localparam logic [3:0] FrameLast = 4'd11;
	localparam int PayloadBytes = 9;

	localparam logic [7:0]  CrcPoly  = 8'h8C;
	localparam logic [30:0] NanFloor = 31'h7F800000;

	// counters saturate at 2^COUNT_BITS-1, never above the 16-bit totals
	localparam int COUNT_BITS = 16;
	localparam int CntW = (COUNT_BITS < 16) ? COUNT_BITS : 16;

	localparam int OutBits = 112;

	typedef struct packed {
		logic [7:0]  sync_byte;
		logic [30:0] magnitude_limit;
	} cfg_t;

	function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			if (c[0]) c = (c >> 1) ^ CrcPoly;
			else c = c >> 1;
		end
		return c;
	endfunction

	// magnitude above limit, nan patterns excluded, infinity counts
	function automatic logic too_big(input logic [31:0] bits, input logic [30:0] limit);
		logic [30:0] mag;
		mag = bits[30:0];
		return (mag > limit) && (mag <= NanFloor);
	endfunction

endpackage

// ----- rtl/crc8fpr_cfg.sv -----
// apb-style configuration registers of the crc-8 framed packet receiver
// depends on crc8fpr_pkg
module crc8fpr_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [crc8fpr_pkg::AddrBits-1:0]  paddr,
	input  logic [crc8fpr_pkg::DataBits-1:0]  pwdata,
	output logic [crc8fpr_pkg::DataBits-1:0]  prdata,
	output logic                              pready,
	output crc8fpr_pkg::cfg_t                 cfg
);

	logic [7:0]  sync_q;
	logic [30:0] limit_q;
	logic        wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_q  <= crc8fpr_pkg::SyncReset;
			limit_q <= crc8fpr_pkg::LimitReset;
		end else if (wr_en) begin
			unique case (paddr[2])
				crc8fpr_pkg::RegSync:  sync_q  <= pwdata[7:0];
				crc8fpr_pkg::RegLimit: limit_q <= pwdata[30:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			crc8fpr_pkg::RegSync:  prdata = {24'd0, sync_q};
			crc8fpr_pkg::RegLimit: prdata = {1'b0, limit_q};
			default:               prdata = '0;
		endcase
	end

	assign cfg.sync_byte       = sync_q;
	assign cfg.magnitude_limit = limit_q;

endmodule

// ----- rtl/crc8_framed_packet_receiver_unit.sv -----
// top level of the crc-8 framed packet receiver: byte input register, frame
// state, crc and range check, result register; depends on crc8fpr_pkg,
// crc8fpr_cfg and crc8_framed_packet_receiver_unit_assert.svh
//
//  channel   direction  signals                        request
//  s_*       in         tvalid tready tdata[7:0]       one received byte
//  m_*       out        tvalid tready tdata[111:0]     one checked frame
//  apb       in/out     psel penable pwrite paddr ...  register write/read
//
// one byte per cycle while no check byte waits: a byte lands in the input register,
// and from there updates frame position, running crc and payload bytes, or on the
// check byte loads the result register, which drives m_tvalid.
// only a check byte waits, while the result register is full and m_tready low.
// arst_n clears position, crc, counters and valid flags; payload has no reset.
`include "crc8_framed_packet_receiver_unit_assert.svh"

module crc8_framed_packet_receiver_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [7:0]                        s_tdata,   // rx_byte[7:0]
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// crc_ok[0], first_param_id[4:1], second_param_id[8:5], value_a_bits[40:9],
	// value_b_bits[72:41], out_of_range[73], crc_error_total[89:74],
	// bad_value_total[105:90], zero[111:106]
	output logic [crc8fpr_pkg::OutBits-1:0]   m_tdata,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [crc8fpr_pkg::AddrBits-1:0]  paddr,
	input  logic [crc8fpr_pkg::DataBits-1:0]  pwdata,
	output logic [crc8fpr_pkg::DataBits-1:0]  prdata,
	output logic                              pready
);

	localparam logic [crc8fpr_pkg::CntW-1:0] CountCap = '1;

	crc8fpr_pkg::cfg_t cfg;

	logic       valid_s1;
	logic [7:0] byte_s1;

	logic [3:0] pos_q;
	logic [7:0] crc_q;
	logic [7:0] payload_q [crc8fpr_pkg::PayloadBytes];
	logic [crc8fpr_pkg::CntW-1:0] crc_cnt_q;
	logic [crc8fpr_pkg::CntW-1:0] bad_cnt_q;

	logic       m_valid_q;
	logic [crc8fpr_pkg::OutBits-1:0] m_data_q;

	logic       is_check;
	logic       out_free;
	logic       s1_go;
	logic       out_load;
	logic       hunting;
	logic       crc_ok;
	logic       bad;
	logic [31:0] va;
	logic [31:0] vb;
	logic [crc8fpr_pkg::CntW-1:0] crc_cnt_nxt;
	logic [crc8fpr_pkg::CntW-1:0] bad_cnt_nxt;
	logic [3:0] wr_idx;

	crc8fpr_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// only the check byte needs the result register
	assign hunting  = (pos_q == crc8fpr_pkg::PosHunt) || (pos_q > crc8fpr_pkg::FrameLast);
	assign is_check = (pos_q == crc8fpr_pkg::FrameLast);
	assign out_free = !m_valid_q || m_tready;
	assign s1_go    = valid_s1 && (!is_check || out_free);
	assign out_load = s1_go && is_check;
	assign s_tready = !valid_s1 || s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	// frame check on the stored payload
	assign va     = {payload_q[4], payload_q[3], payload_q[2], payload_q[1]};
	assign vb     = {payload_q[8], payload_q[7], payload_q[6], payload_q[5]};
	assign crc_ok = (crc_q == byte_s1);
	assign bad    = crc_ok && (crc8fpr_pkg::too_big(va, cfg.magnitude_limit)
		|| crc8fpr_pkg::too_big(vb, cfg.magnitude_limit));
	assign crc_cnt_nxt = (!crc_ok && crc_cnt_q != CountCap) ? crc_cnt_q + 1'b1 : crc_cnt_q;
	assign bad_cnt_nxt = (bad && bad_cnt_q != CountCap) ? bad_cnt_q + 1'b1 : bad_cnt_q;
	assign wr_idx = pos_q - 4'd2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= crc8fpr_pkg::PosHunt;
			crc_q     <= 8'd0;
			crc_cnt_q <= '0;
			bad_cnt_q <= '0;
		end else if (s1_go) begin
			if (hunting) begin
				if (byte_s1 == cfg.sync_byte) begin
					pos_q <= crc8fpr_pkg::PosFirst;
					crc_q <= 8'd0;
				end else begin
					pos_q <= crc8fpr_pkg::PosHunt;
				end
			end else if (pos_q <= crc8fpr_pkg::CrcLast) begin
				crc_q <= crc8fpr_pkg::crc8_update(crc_q, byte_s1);
				pos_q <= pos_q + 4'd1;
			end else begin
				pos_q     <= crc8fpr_pkg::PosHunt;
				crc_cnt_q <= crc_cnt_nxt;
				bad_cnt_q <= bad_cnt_nxt;
			end
		end
	end

	// frame bytes 2..10
	always_ff @(posedge clk) begin
		if (s1_go && !hunting && pos_q >= 4'd2 && pos_q <= crc8fpr_pkg::CrcLast) begin
			payload_q[wr_idx] <= byte_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_data_q <= {6'd0,
				16'(bad_cnt_nxt), 16'(crc_cnt_nxt), bad,
				vb, va, payload_q[0][7:4], payload_q[0][3:0], crc_ok};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	`CRC8FPR_ASSERT(pos_in_frame, 1'b1, pos_q <= crc8fpr_pkg::FrameLast)
	`CRC8FPR_ASSERT(stall_only_when_full, valid_s1 && !s1_go, m_valid_q && !m_tready)
	`CRC8FPR_ASSERT_NEXT(back_to_hunt, out_load, pos_q == crc8fpr_pkg::PosHunt && m_valid_q)
	`CRC8FPR_ASSERT(range_needs_crc, m_valid_q && m_data_q[73], m_data_q[0])
	`CRC8FPR_ASSERT_NEXT(crc_cnt_no_drop, 1'b1, crc_cnt_q >= $past(crc_cnt_q))

endmodule
